// File: src/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared constants and types for the packet tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mt_pkg;

  // Number of mouse buttons reported (left, right, middle).
  localparam int BTN_BITS = 3;

  // Width of a signed movement delta after negation (-127 .. 128).
  localparam int DELTA_BITS = 9;

  // Position of a byte within a three-byte packet.
  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } cfg_reg_t;

  // Button and packet status that travels with each result.
  typedef struct packed {
    logic [BTN_BITS-1:0] buttons;
    logic [BTN_BITS-1:0] button_changes;
    logic                packet_done;
  } pkt_status_t;

endpackage

`default_nettype wire

// File: src/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Turns aux-port controller bytes into a clamped cursor position and buttons.
// ----------------------------------------------------------------------------
// The tracker takes one controller byte per item, tagged with an aux flag, and
// returns exactly one result item for every input item. Bytes without the aux
// flag leave all state untouched. Flagged bytes are collected into three-byte
// PS/2 mouse packets; the third byte moves the cursor by the X delta and by the
// negated Y delta (only when some delta is nonzero), clamps each coordinate to
// the configured minimum and then maximum, and reports the new buttons together
// with a mask of the buttons that changed. Other items echo the current state
// with no change mask and packet_done low. The block accepts one item in every
// cycle while the result side does not stall; each item waits in the input
// register until the result register can load, then its result is loaded into
// the result register, where it waits until it is taken. The packet update
// itself is a single pass through the add and compare logic between the two
// registers. Stall on the result side reaches the input side in the same cycle
// once both registers are full. Bound registers should be written only while
// no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  aux_flag,
  input  wire logic [7:0]            data_byte,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      cursor_x,
  output logic [COORD_BITS-1:0]      cursor_y,
  output logic [BTN_BITS-1:0]        buttons,
  output logic [BTN_BITS-1:0]        button_changes,
  output logic                       packet_done,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data
);

  // Bound registers. The reset values are cut to the coordinate width.
  logic [COORD_BITS-1:0] min_x;
  logic [COORD_BITS-1:0] min_y;
  logic [COORD_BITS-1:0] max_x;
  logic [COORD_BITS-1:0] max_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0;
      min_y <= '0;
      max_x <= COORD_BITS'(319);
      max_y <= COORD_BITS'(199);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: min_x <= cfg_data;
        REG_MIN_Y: min_y <= cfg_data;
        REG_MAX_X: max_x <= cfg_data;
        REG_MAX_Y: max_y <= cfg_data;
        default:   min_x <= min_x;
      endcase
    end
  end

  // Input register.
  logic       s1_valid;
  logic       s1_aux;
  logic [7:0] s1_data;
  logic       out_free;
  logic       step;
  logic       in_take;

  // The result register can load when empty or when its item leaves now.
  assign out_free = !out_valid || !out_stall;
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_aux  <= aux_flag;
      s1_data <= data_byte;
    end
  end

  // Packet logic: state advances when the registered item moves on.
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  pkt_status_t           res_status;

  ps2mt_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .aux_flag  (s1_aux),
    .data_byte (s1_data),
    .min_x     (min_x),
    .min_y     (min_y),
    .max_x     (max_x),
    .max_y     (max_y),
    .cursor_x  (res_x),
    .cursor_y  (res_y),
    .status    (res_status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cursor_x       <= res_x;
      cursor_y       <= res_y;
      buttons        <= res_status.buttons;
      button_changes <= res_status.button_changes;
      packet_done    <= res_status.packet_done;
    end
  end

endmodule

`default_nettype wire

// File: src/ps2mt_clamp.sv
// ----------------------------------------------------------------------------
// PS/2 mouse coordinate move and clamp
// Adds a signed delta to a coordinate and clamps the sum to [lo, hi].
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_clamp
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]        pos,
  input  wire logic signed [DELTA_BITS-1:0] delta,
  input  wire logic [COORD_BITS-1:0]        lo,
  input  wire logic [COORD_BITS-1:0]        hi,
  output logic [COORD_BITS-1:0]             result
);

  localparam int SUM_BITS = COORD_BITS + 2;

  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] lo_s;
  logic signed [SUM_BITS-1:0] hi_s;
  logic signed [SUM_BITS-1:0] after_lo;

  always_comb begin
    sum  = $signed({2'b00, pos}) + $signed({{(SUM_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta});
    lo_s = $signed({2'b00, lo});
    hi_s = $signed({2'b00, hi});
    // The minimum is applied first, so a maximum below the minimum wins.
    after_lo = (sum < lo_s) ? lo_s : sum;
    if (after_lo > hi_s) begin
      result = hi;
    end else begin
      result = after_lo[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/ps2mt_core.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker core
// Packet assembly, cursor and button state, and the next result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_core
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic                  aux_flag,
  input  wire logic [7:0]            data_byte,
  input  wire logic [COORD_BITS-1:0] min_x,
  input  wire logic [COORD_BITS-1:0] min_y,
  input  wire logic [COORD_BITS-1:0] max_x,
  input  wire logic [COORD_BITS-1:0] max_y,
  output logic [COORD_BITS-1:0]      cursor_x,
  output logic [COORD_BITS-1:0]      cursor_y,
  output pkt_status_t                status
);

  logic [1:0]            byte_index;
  logic [1:0]            byte_index_next;
  logic [7:0]            first_byte;
  logic [7:0]            first_byte_next;
  logic [7:0]            second_byte;
  logic [7:0]            second_byte_next;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [BTN_BITS-1:0]   button_state;

  logic                         last_byte;
  logic                         moved;
  logic signed [DELTA_BITS-1:0] delta_x;
  logic signed [DELTA_BITS-1:0] delta_y;
  logic [COORD_BITS-1:0]        clamp_x;
  logic [COORD_BITS-1:0]        clamp_y;

  // Y grows downward on screen, so the mouse Y delta is negated.
  assign delta_x = $signed({second_byte[7], second_byte});
  assign delta_y = -$signed({data_byte[7], data_byte});

  ps2mt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .pos    (pos_x),
    .delta  (delta_x),
    .lo     (min_x),
    .hi     (max_x),
    .result (clamp_x)
  );

  ps2mt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .pos    (pos_y),
    .delta  (delta_y),
    .lo     (min_y),
    .hi     (max_y),
    .result (clamp_y)
  );

  always_comb begin
    byte_index_next  = byte_index;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    last_byte        = 1'b0;
    if (aux_flag) begin
      case (byte_index)
        IDX_FIRST: begin
          first_byte_next = data_byte;
          byte_index_next = IDX_SECOND;
        end
        IDX_SECOND: begin
          second_byte_next = data_byte;
          byte_index_next  = IDX_THIRD;
        end
        default: begin
          // Third byte; an out-of-range index is handled the same way.
          last_byte       = 1'b1;
          byte_index_next = IDX_FIRST;
        end
      endcase
    end

    // With both deltas zero the position is left alone, not even clamped.
    moved = (second_byte != 8'h00) || (data_byte != 8'h00);

    cursor_x = (last_byte && moved) ? clamp_x : pos_x;
    cursor_y = (last_byte && moved) ? clamp_y : pos_y;

    status.packet_done    = last_byte;
    status.buttons        = last_byte ? first_byte[BTN_BITS-1:0] : button_state;
    status.button_changes = last_byte ? (first_byte[BTN_BITS-1:0] ^ button_state)
                                      : {BTN_BITS{1'b0}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= IDX_FIRST;
      first_byte   <= 8'h00;
      second_byte  <= 8'h00;
      pos_x        <= '0;
      pos_y        <= '0;
      button_state <= '0;
    end else if (step) begin
      byte_index   <= byte_index_next;
      first_byte   <= first_byte_next;
      second_byte  <= second_byte_next;
      pos_x        <= cursor_x;
      pos_y        <= cursor_y;
      button_state <= status.buttons;
    end
  end

endmodule

`default_nettype wire

// File: test/tb_ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Sends aux and non-aux controller bytes through the tracker under random input
// gaps and result stalls, and checks every result item against a typed report
// or a cycle-free model of packet assembly, cursor motion, clamping and buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ps2_mouse_packet_tracker;
  import ps2mt_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int CYCLE_LIMIT = 200000;
  // Aux items sent under each bound setting in the random part.
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_PHASES  = 7;
  localparam int NUM_ROWS    = 28;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One result item as the tracker reports it.
  typedef struct packed {
    coord_t      x;
    coord_t      y;
    pkt_status_t status;
  } cursor_report_t;

  // A directed stimulus row. When known is set, the report is typed in by hand
  // and queued instead of the model's own answer.
  typedef struct packed {
    logic                aux;
    logic [7:0]          data;
    logic                known;
    coord_t              x;
    coord_t              y;
    logic [BTN_BITS-1:0] btn;
    logic [BTN_BITS-1:0] chg;
    logic                done;
  } byte_row_t;

  // Bound settings for the random phases: min_x, min_y, max_x, max_y.
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } window_set_t;

  // The directed rows start from the reset bounds (0..319 by 0..199) and a
  // cursor at the origin.
  localparam byte_row_t BYTE_ROWS [NUM_ROWS] = '{
    // Bytes without the aux flag right after reset show the reset state.
    '{1'b0, 8'hFF, 1'b1, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b0, 8'h00, 1'b1, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    // Full packet: all buttons down, largest right move, largest down move.
    '{1'b1, 8'h07, 1'b1, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h7F, 1'b1, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h80, 1'b1, 12'd127, 12'd128, 3'd7, 3'd7, 1'b1},
    // A non-aux byte between packets carries no change mask.
    '{1'b0, 8'hAA, 1'b1, 12'd127, 12'd128, 3'd7, 3'd0, 1'b0},
    // Overflow and sign bits set, buttons released, both deltas zero.
    '{1'b1, 8'hF8, 1'b1, 12'd127, 12'd128, 3'd7, 3'd0, 1'b0},
    '{1'b1, 8'h00, 1'b1, 12'd127, 12'd128, 3'd7, 3'd0, 1'b0},
    '{1'b1, 8'h00, 1'b1, 12'd127, 12'd128, 3'd0, 3'd7, 1'b1},
    // Non-aux byte inside a packet, y driven past its maximum.
    '{1'b1, 8'h01, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b0, 8'h55, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h7F, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h81, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    // x driven past its maximum, y delta zero.
    '{1'b1, 8'h03, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h7F, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    // Largest left move with the largest up move, then with the largest down move.
    '{1'b1, 8'h06, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h80, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h7F, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h04, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h80, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h80, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    // x driven below its minimum.
    '{1'b1, 8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h80, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    // Only the y delta is nonzero.
    '{1'b1, 8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h00, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0},
    '{1'b1, 8'h01, 1'b0, 12'd0,   12'd0,   3'd0, 3'd0, 1'b0}
  };

  // Full range, a plain window, everything pinned to the top, minimum above
  // maximum, everything pinned to zero, a narrow window away from the origin,
  // and the reset bounds again for the final stretch without idling.
  localparam window_set_t PHASE_BOUNDS [NUM_PHASES] = '{
    '{12'd0,    12'd0,    12'd4095, 12'd4095},
    '{12'd10,   12'd20,   12'd300,  12'd150},
    '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
    '{12'd300,  12'd250,  12'd100,  12'd50},
    '{12'd0,    12'd0,    12'd0,    12'd0},
    '{12'd1000, 12'd2000, 12'd1063, 12'd2015},
    '{12'd0,    12'd0,    12'd319,  12'd199}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                aux_flag;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_stall;
  coord_t              cursor_x;
  coord_t              cursor_y;
  logic [BTN_BITS-1:0] buttons;
  logic [BTN_BITS-1:0] button_changes;
  logic                packet_done;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  coord_t              cfg_data;

  ps2_mouse_packet_tracker #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .aux_flag      (aux_flag),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .buttons       (buttons),
    .button_changes(button_changes),
    .packet_done   (packet_done),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Model copy of the bound registers.
  coord_t bound_min_x = '0;
  coord_t bound_min_y = '0;
  coord_t bound_max_x = 12'd319;
  coord_t bound_max_y = 12'd199;

  // Model copy of the packet assembly and cursor state.
  logic [1:0]          pkt_slot   = IDX_FIRST;
  logic [7:0]          pkt_head   = '0;
  logic [7:0]          pkt_dx     = '0;
  coord_t              track_x    = '0;
  coord_t              track_y    = '0;
  logic [BTN_BITS-1:0] track_btn  = '0;

  // Reports still owed by the tracker, oldest first.
  cursor_report_t owed_reports[$];

  int   errors     = 0;
  bit   idle_on    = 1'b1;
  int   stall_left = 0;
  int   cycles     = 0;

  // Moves one coordinate and clamps it. The minimum is applied first, so a
  // minimum above the maximum leaves the coordinate at the maximum.
  function automatic coord_t move_within(coord_t pos, int delta, coord_t lo, coord_t hi);
    int v;
    v = int'(pos) + delta;
    if (v < int'(lo)) v = int'(lo);
    if (v > int'(hi)) v = int'(hi);
    return v[COORD_BITS-1:0];
  endfunction

  // Advances the model by one accepted byte and returns the report it causes.
  task automatic advance_tracker(input logic aux, input logic [7:0] data,
                                 output cursor_report_t rep);
    logic [BTN_BITS-1:0] chg;
    logic                done;
    chg  = '0;
    done = 1'b0;
    if (aux) begin
      case (pkt_slot)
        IDX_FIRST: begin
          pkt_head = data;
          pkt_slot = IDX_SECOND;
        end
        IDX_SECOND: begin
          pkt_dx   = data;
          pkt_slot = IDX_THIRD;
        end
        default: begin
          // Third byte: y on the mouse counts up, on the screen it counts down.
          if (pkt_dx != 8'h00 || data != 8'h00) begin
            track_x = move_within(track_x, int'($signed(pkt_dx)), bound_min_x, bound_max_x);
            track_y = move_within(track_y, -int'($signed(data)), bound_min_y, bound_max_y);
          end
          chg       = pkt_head[BTN_BITS-1:0] ^ track_btn;
          track_btn = pkt_head[BTN_BITS-1:0];
          pkt_slot  = IDX_FIRST;
          done      = 1'b1;
        end
      endcase
    end
    rep.x                     = track_x;
    rep.y                     = track_y;
    rep.status.buttons        = track_btn;
    rep.status.button_changes = chg;
    rep.status.packet_done    = done;
  endtask

  // Offers one item, with an optional gap first, and waits for its acceptance.
  // In the accepting cycle in_valid is left high so the next item can follow
  // back to back.
  task automatic push_byte(input logic aux, input logic [7:0] data,
                           input bit known = 1'b0,
                           input cursor_report_t typed = '0);
    cursor_report_t rep;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    aux_flag  <= aux;
    data_byte <= data;
    do @(posedge clk); while (in_stall);
    advance_tracker(aux, data, rep);
    owed_reports.push_back(known ? typed : rep);
  endtask

  // Stops offering items and waits until every owed report has come out, then
  // lets the two-stage pipeline settle.
  task automatic drain_tracker();
    in_valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input coord_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_MIN_X: bound_min_x = value;
      REG_MIN_Y: bound_min_y = value;
      REG_MAX_X: bound_max_x = value;
      default:   bound_max_y = value;
    endcase
  endtask

  task automatic set_bounds(input window_set_t b);
    drain_tracker();
    write_reg(REG_MIN_X, b.min_x);
    write_reg(REG_MIN_Y, b.min_y);
    write_reg(REG_MAX_X, b.max_x);
    write_reg(REG_MAX_Y, b.max_y);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Deltas lean toward zero, small moves and the extremes, with a share of
  // fully random bytes so every bit toggles.
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'($urandom_range(0, 255));
      2:       return 8'($signed($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 8'h7F;
          1:       return 8'h80;
          2:       return 8'h81;
          default: return 8'h01;
        endcase
      end
    endcase
  endfunction

  // Result-side stall, in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every accepted result item is checked against the oldest owed report.
  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_reports.size() == 0) begin
        $error("unexpected result item: x %0d y %0d", cursor_x, cursor_y);
        errors++;
      end else begin
        want = owed_reports.pop_front();
        if (cursor_x !== want.x) begin
          $error("cursor_x: expected %0d, got %0d", want.x, cursor_x);
          errors++;
        end
        if (cursor_y !== want.y) begin
          $error("cursor_y: expected %0d, got %0d", want.y, cursor_y);
          errors++;
        end
        if (buttons !== want.status.buttons) begin
          $error("buttons: expected %0d, got %0d", want.status.buttons, buttons);
          errors++;
        end
        if (button_changes !== want.status.button_changes) begin
          $error("button_changes: expected %0d, got %0d",
                 want.status.button_changes, button_changes);
          errors++;
        end
        if (packet_done !== want.status.packet_done) begin
          $error("packet_done: expected %0d, got %0d",
                 want.status.packet_done, packet_done);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ps2_mouse_packet_tracker test failed");
    $finish;
  end

  initial begin
    cursor_report_t typed;
    int sent;
    int kind;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    aux_flag  <= 1'b0;
    data_byte <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MIN_X;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run on the reset bounds, which checks them as well.
    for (int i = 0; i < NUM_ROWS; i++) begin
      typed.x                     = BYTE_ROWS[i].x;
      typed.y                     = BYTE_ROWS[i].y;
      typed.status.buttons        = BYTE_ROWS[i].btn;
      typed.status.button_changes = BYTE_ROWS[i].chg;
      typed.status.packet_done    = BYTE_ROWS[i].done;
      push_byte(BYTE_ROWS[i].aux, BYTE_ROWS[i].data, BYTE_ROWS[i].known, typed);
    end

    // Random part: mostly whole packets with random content, some with a
    // non-aux byte slipped in, plus lone non-aux bytes and lone aux bytes that
    // knock the packet alignment off by one.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_bounds(PHASE_BOUNDS[p]);
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          push_byte(1'b1, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 7) == 0) push_byte(1'b0, 8'($urandom_range(0, 255)));
          push_byte(1'b1, pick_delta());
          if ($urandom_range(0, 7) == 0) push_byte(1'b0, 8'($urandom_range(0, 255)));
          push_byte(1'b1, pick_delta());
          sent += 3;
        end else if (kind == 8) begin
          push_byte(1'b0, 8'($urandom_range(0, 255)));
        end else begin
          push_byte(1'b1, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end

    drain_tracker();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("ps2_mouse_packet_tracker test passed");
    end else begin
      $display("ps2_mouse_packet_tracker test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
